// File: rtl/cs_pkg.sv
// shared types and constants for the comment stripper
// scan modes, character codes and the front-to-back queue entry
// no dependencies
`default_nettype none

package cs_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_STR        = 3'd2,
    MODE_STR_BS     = 3'd3,
    MODE_BLOCK      = 3'd4,
    MODE_BLOCK_STAR = 3'd5,
    MODE_LINE       = 3'd6
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one accepted byte's worth of results; cnt is 1..3
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      cnt;
    logic            char_valid;
    logic            text_done;
  } cs_entry_t;

endpackage

`default_nettype wire

// File: rtl/cs_front.sv
// front end: accepts text bytes, runs the scan mode machine and builds
// the list of result bytes for each transfer
// depends on cs_pkg
`default_nettype none

module cs_front (
  input  wire                logic      clk,
  input  wire                logic      rst,
  input  wire                logic      in_valid,
  input  wire                logic [7:0] in_char,
  input  wire                logic      text_end,
  output logic                          in_ready,
  output logic                          q_push,
  output cs_pkg::cs_entry_t             q_entry,
  input  wire                logic      q_full
);

  cs_pkg::mode_t   mode;
  cs_pkg::mode_t   mode_next;
  cs_pkg::mode_t   nb_mode;
  logic            nb_emit;
  logic [7:0]      nb_char;
  logic [2:0][7:0] chars;
  logic [1:0]      n;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cs_pkg::MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  always_comb begin
    // what a byte does in normal mode
    nb_emit = 1'b1;
    nb_char = in_char;
    nb_mode = cs_pkg::MODE_NORMAL;
    if (in_char == cs_pkg::CH_QUOTE) begin
      nb_mode = cs_pkg::MODE_STR;
    end else if (in_char == cs_pkg::CH_SLASH) begin
      nb_emit = 1'b0;
      nb_mode = cs_pkg::MODE_SLASH;
    end else if (in_char == cs_pkg::CH_NL) begin
      nb_char = cs_pkg::CH_SPACE;
    end

    chars     = '0;
    n         = 2'd0;
    mode_next = mode;
    case (mode)
      cs_pkg::MODE_SLASH: begin
        if (in_char == cs_pkg::CH_STAR) begin
          mode_next = cs_pkg::MODE_BLOCK;
        end else if (in_char == cs_pkg::CH_SLASH) begin
          mode_next = cs_pkg::MODE_LINE;
        end else begin
          // pending slash goes out ahead of this byte
          chars[0]  = cs_pkg::CH_SLASH;
          chars[1]  = nb_emit ? nb_char : 8'h00;
          n         = nb_emit ? 2'd2 : 2'd1;
          mode_next = nb_mode;
        end
      end
      cs_pkg::MODE_STR: begin
        chars[0] = in_char;
        n        = 2'd1;
        if (in_char == cs_pkg::CH_QUOTE) begin
          mode_next = cs_pkg::MODE_NORMAL;
        end else if (in_char == cs_pkg::CH_BSLASH) begin
          mode_next = cs_pkg::MODE_STR_BS;
        end
      end
      cs_pkg::MODE_STR_BS: begin
        chars[0] = in_char;
        n        = 2'd1;
        if (in_char != cs_pkg::CH_BSLASH) begin
          mode_next = cs_pkg::MODE_STR;
        end
      end
      cs_pkg::MODE_BLOCK: begin
        if (in_char == cs_pkg::CH_STAR) begin
          mode_next = cs_pkg::MODE_BLOCK_STAR;
        end
      end
      cs_pkg::MODE_BLOCK_STAR: begin
        if (in_char == cs_pkg::CH_SLASH) begin
          mode_next = cs_pkg::MODE_NORMAL;
        end else if (in_char != cs_pkg::CH_STAR) begin
          mode_next = cs_pkg::MODE_BLOCK;
        end
      end
      cs_pkg::MODE_LINE: begin
        if (in_char == cs_pkg::CH_NL) begin
          chars[0]  = cs_pkg::CH_SPACE;
          n         = 2'd1;
          mode_next = cs_pkg::MODE_NORMAL;
        end
      end
      default: begin
        chars[0]  = nb_char;
        n         = {1'b0, nb_emit};
        mode_next = nb_mode;
      end
    endcase

    // end of text: flush a pending slash, close an open string
    if (text_end) begin
      if (mode_next == cs_pkg::MODE_SLASH) begin
        chars[n] = cs_pkg::CH_SLASH;
        n        = n + 2'd1;
      end else if (mode_next == cs_pkg::MODE_STR || mode_next == cs_pkg::MODE_STR_BS) begin
        chars[n] = cs_pkg::CH_QUOTE;
        n        = n + 2'd1;
      end
      mode_next = cs_pkg::MODE_NORMAL;
    end

    q_entry.chars      = chars;
    q_entry.cnt        = (n == 2'd0) ? 2'd1 : n;
    q_entry.char_valid = (n != 2'd0);
    q_entry.text_done  = text_end;
    q_push             = accept && ((n != 2'd0) || text_end);
  end

endmodule

`default_nettype wire

// File: rtl/cs_queue.sv
// short queue between the front end and the output serializer
// flip-flop storage, read at the head only
// depends on cs_pkg
`default_nettype none

module cs_queue (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic push,
  input  cs_pkg::cs_entry_t        push_entry,
  output logic                     full,
  output logic                     nonempty,
  input  wire                logic pop,
  output cs_pkg::cs_entry_t        head
);

  cs_pkg::cs_entry_t             slots [cs_pkg::QDEPTH];
  logic [cs_pkg::QPTR_W-1:0]     wr_ptr;
  logic [cs_pkg::QPTR_W-1:0]     rd_ptr;
  logic [cs_pkg::QPTR_W:0]       count;

  assign full     = (count == (cs_pkg::QPTR_W+1)'(cs_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cs_back.sv
// back end: walks the bytes of the head queue entry, one result per cycle
// unless out_ready holds it off, into the output register
// depends on cs_pkg
`default_nettype none

module cs_back (
  input  wire                logic       clk,
  input  wire                logic       rst,
  input  wire                logic       q_nonempty,
  input  cs_pkg::cs_entry_t              q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire                logic       out_ready,
  output logic [7:0]                     out_char,
  output logic                           char_valid,
  output logic                           run_last,
  output logic                           text_done
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = q_nonempty && (!out_valid || out_ready);
  assign is_last = (idx == q_head.cnt - 2'd1);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char   <= q_head.chars[idx];
      char_valid <= q_head.char_valid;
      run_last   <= is_last;
      text_done  <= is_last && q_head.text_done;
    end
  end

endmodule

`default_nettype wire

// File: rtl/comment_stripper.sv
// Comment stripper: removes slash-star and double-slash comments from a byte
// stream, turns newlines outside strings into spaces and passes quoted strings
// unchanged. One input byte is taken per cycle while the 4-entry queue between
// the mode machine and the output serializer has room. Each byte yields zero to
// three output transfers; the serializer sends one per cycle while m_tready is
// high, and the queue absorbs the difference. An accepted byte's results are
// written into the queue, then into the output register. A byte flagged with
// tlast ends the text: a pending slash is sent, an open string gets a closing
// quote, and if nothing else comes out an empty marker (char_valid low) is sent,
// carrying tlast and text_done.
// depends on cs_pkg, cs_front, cs_queue, cs_back
`default_nettype none

module comment_stripper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_char
  input  wire logic       s_tlast,   // text_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic [1:0]      m_tuser,   // [0] char_valid, [1] text_done
  output logic            m_tlast    // run_last
);

  cs_pkg::cs_entry_t q_in;
  cs_pkg::cs_entry_t q_head;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_nonempty;

  cs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_char  (s_tdata),
    .text_end (s_tlast),
    .in_ready (s_tready),
    .q_push   (q_push),
    .q_entry  (q_in),
    .q_full   (q_full)
  );

  cs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .pop        (q_pop),
    .head       (q_head)
  );

  cs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (m_tdata),
    .char_valid (m_tuser[0]),
    .run_last   (m_tlast),
    .text_done  (m_tuser[1])
  );

endmodule

`default_nettype wire

// File: sim/tb_comment_stripper.sv
// testbench for comment_stripper: drives byte streams with bursts and gaps,
// predicts the stripped output transfers per byte and checks them in order
// depends on cs_pkg and the comment_stripper rtl
`default_nettype none

module tb_comment_stripper;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       run_last;
    logic       text_done;
  } strip_result_t;

  typedef enum int {
    TOK_BYTE,
    TOK_STRING,
    TOK_BLOCK,
    TOK_LINE,
    TOK_SLASH,
    TOK_NEWLINE,
    TOK_END,
    TOK_SPECIAL
  } token_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;   // [7:0] out_char
  logic [1:0] m_tuser;   // [0] char_valid, [1] text_done
  logic       m_tlast;   // run_last

  strip_result_t stripped_q[$];
  strip_result_t want;
  cs_pkg::mode_t strip_mode = cs_pkg::MODE_NORMAL;

  int errors      = 0;
  int bytes_sent  = 0;
  int outs_seen   = 0;
  int texts_ended = 0;
  int cycles      = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int hold_req    = 0;
  int hold_left   = 0;
  int stall_style = 0;
  int stall_phase = 0;

  comment_stripper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, stripped_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // expected transfers for one accepted byte, advancing the scan mode
  function automatic void predict_byte(input logic [7:0] c, input logic last);
    logic [7:0]    ob [3];
    int            n;
    int            k;
    bit            as_plain;
    strip_result_t r;
    n = 0;
    as_plain = 1'b0;
    case (strip_mode)
      cs_pkg::MODE_SLASH: begin
        if (c == cs_pkg::CH_STAR) strip_mode = cs_pkg::MODE_BLOCK;
        else if (c == cs_pkg::CH_SLASH) strip_mode = cs_pkg::MODE_LINE;
        else begin
          ob[n] = cs_pkg::CH_SLASH;
          n++;
          as_plain = 1'b1;
        end
      end
      cs_pkg::MODE_STR: begin
        ob[n] = c;
        n++;
        if (c == cs_pkg::CH_QUOTE) strip_mode = cs_pkg::MODE_NORMAL;
        else if (c == cs_pkg::CH_BSLASH) strip_mode = cs_pkg::MODE_STR_BS;
      end
      cs_pkg::MODE_STR_BS: begin
        ob[n] = c;
        n++;
        if (c != cs_pkg::CH_BSLASH) strip_mode = cs_pkg::MODE_STR;
      end
      cs_pkg::MODE_BLOCK: begin
        if (c == cs_pkg::CH_STAR) strip_mode = cs_pkg::MODE_BLOCK_STAR;
      end
      cs_pkg::MODE_BLOCK_STAR: begin
        if (c == cs_pkg::CH_SLASH) strip_mode = cs_pkg::MODE_NORMAL;
        else if (c != cs_pkg::CH_STAR) strip_mode = cs_pkg::MODE_BLOCK;
      end
      cs_pkg::MODE_LINE: begin
        if (c == cs_pkg::CH_NL) begin
          ob[n] = cs_pkg::CH_SPACE;
          n++;
          strip_mode = cs_pkg::MODE_NORMAL;
        end
      end
      default: as_plain = 1'b1;
    endcase
    if (as_plain) begin
      if (c == cs_pkg::CH_QUOTE) begin
        ob[n] = cs_pkg::CH_QUOTE;
        n++;
        strip_mode = cs_pkg::MODE_STR;
      end else if (c == cs_pkg::CH_SLASH) begin
        strip_mode = cs_pkg::MODE_SLASH;
      end else begin
        ob[n] = (c == cs_pkg::CH_NL) ? cs_pkg::CH_SPACE : c;
        n++;
        strip_mode = cs_pkg::MODE_NORMAL;
      end
    end
    if (last) begin
      // flush a pending slash or close an open string
      if (strip_mode == cs_pkg::MODE_SLASH && n < 3) begin
        ob[n] = cs_pkg::CH_SLASH;
        n++;
      end else if ((strip_mode == cs_pkg::MODE_STR || strip_mode == cs_pkg::MODE_STR_BS)
                   && n < 3) begin
        ob[n] = cs_pkg::CH_QUOTE;
        n++;
      end
      strip_mode = cs_pkg::MODE_NORMAL;
      texts_ended++;
    end
    if (last && n == 0) begin
      r = '{ch: 8'h00, char_valid: 1'b0, run_last: 1'b1, text_done: 1'b1};
      stripped_q.insert(stripped_q.size(), r);
    end else begin
      for (k = 0; k < n; k++) begin
        r.ch         = ob[k];
        r.char_valid = 1'b1;
        r.run_last   = (k == n - 1);
        r.text_done  = (k == n - 1) && last;
        stripped_q.insert(stripped_q.size(), r);
      end
    end
  endfunction

  // receiver: long hold-off on request, otherwise one of four stall styles, re-picked at random
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    stall_phase++;
    if (stall_phase % 64 == 0) stall_style = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (stall_style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (stall_phase % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      outs_seen++;
      if (stripped_q.size() == 0) begin
        $error("output transfer with nothing expected: out_char %h", m_tdata);
        errors++;
      end else begin
        want = stripped_q.pop_front();
        if (m_tdata !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.char_valid) begin
          $error("char_valid expected %b actual %b", want.char_valid, m_tuser[0]);
          errors++;
        end
        if (m_tlast !== want.run_last) begin
          $error("run_last expected %b actual %b", want.run_last, m_tlast);
          errors++;
        end
        if (m_tuser[1] !== want.text_done) begin
          $error("text_done expected %b actual %b", want.text_done, m_tuser[1]);
          errors++;
        end
      end
    end
  end

  // called at a rising edge; returns at a rising edge
  task automatic send_byte(input logic [7:0] c, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(c, last);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (stripped_q.size() != 0) @(posedge clk);
    // bytes with no output may still be in flight
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = cs_pkg::CH_SLASH;
      1: v = cs_pkg::CH_STAR;
      2: v = cs_pkg::CH_QUOTE;
      3: v = cs_pkg::CH_BSLASH;
      4: v = cs_pkg::CH_NL;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic test_plain_bytes;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(cs_pkg::CH_NL, 1'b0);
  endtask

  task automatic test_comments;
    send_byte(cs_pkg::CH_SLASH, 1'b0);
    send_byte(cs_pkg::CH_SLASH, 1'b0);
    send_byte(cs_pkg::CH_NL, 1'b0);
    // star followed by other text stays in the comment, a run of stars then slash ends it
    send_byte(cs_pkg::CH_SLASH, 1'b0);
    send_byte(cs_pkg::CH_STAR, 1'b0);
    send_byte(cs_pkg::CH_STAR, 1'b0);
    send_byte("a", 1'b0);
    send_byte(cs_pkg::CH_STAR, 1'b0);
    send_byte(cs_pkg::CH_STAR, 1'b0);
    send_byte(cs_pkg::CH_SLASH, 1'b0);
  endtask

  task automatic test_strings;
    send_byte(cs_pkg::CH_QUOTE, 1'b0);
    send_byte(cs_pkg::CH_BSLASH, 1'b0);
    send_byte(cs_pkg::CH_QUOTE, 1'b0);
    send_byte(cs_pkg::CH_BSLASH, 1'b0);
    send_byte(cs_pkg::CH_BSLASH, 1'b0);
    send_byte(cs_pkg::CH_QUOTE, 1'b0);
    send_byte(cs_pkg::CH_QUOTE, 1'b0);
  endtask

  task automatic test_text_end;
    send_byte(cs_pkg::CH_SLASH, 1'b1);
    send_byte(cs_pkg::CH_SLASH, 1'b0);
    send_byte(cs_pkg::CH_STAR, 1'b1);
    send_byte(cs_pkg::CH_QUOTE, 1'b0);
    send_byte(cs_pkg::CH_BSLASH, 1'b1);
    send_byte(cs_pkg::CH_SLASH, 1'b0);
    send_byte(cs_pkg::CH_QUOTE, 1'b1);
  endtask

  task automatic test_output_hold;
    int i;
    gaps_on = 1'b0;
    @(negedge clk);
    hold_req = HOLD_CYCLES;
    @(posedge clk);
    for (i = 0; i < 12; i++) begin
      send_byte(cs_pkg::CH_SLASH, 1'b0);
      send_byte(cs_pkg::CH_QUOTE, (i % 3) == 2);
    end
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_text;
    int          target;
    int          len;
    int          i;
    int          r;
    token_kind_t kind;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 15) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 11);
      case (r)
        0, 1, 2: kind = TOK_BYTE;
        3, 4:    kind = TOK_STRING;
        5, 6:    kind = TOK_BLOCK;
        7:       kind = TOK_LINE;
        8:       kind = TOK_SLASH;
        9:       kind = TOK_NEWLINE;
        10:      kind = TOK_END;
        default: kind = TOK_SPECIAL;
      endcase
      len = $urandom_range(0, 6);
      case (kind)
        TOK_BYTE: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
        TOK_STRING: begin
          send_byte(cs_pkg::CH_QUOTE, 1'b0);
          for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 3) == 0) send_byte(cs_pkg::CH_BSLASH, 1'b0);
            send_byte(pick_char(), 1'b0);
          end
          if ($urandom_range(0, 5) != 0) send_byte(cs_pkg::CH_QUOTE, 1'b0);
        end
        TOK_BLOCK: begin
          send_byte(cs_pkg::CH_SLASH, 1'b0);
          send_byte(cs_pkg::CH_STAR, 1'b0);
          for (i = 0; i < len; i++) send_byte(pick_char(), 1'b0);
          for (i = 0; i <= $urandom_range(0, 2); i++) send_byte(cs_pkg::CH_STAR, 1'b0);
          send_byte(cs_pkg::CH_SLASH, 1'b0);
        end
        TOK_LINE: begin
          send_byte(cs_pkg::CH_SLASH, 1'b0);
          send_byte(cs_pkg::CH_SLASH, 1'b0);
          for (i = 0; i < len; i++) send_byte(pick_char(), 1'b0);
          send_byte(cs_pkg::CH_NL, 1'b0);
        end
        TOK_SLASH: begin
          send_byte(cs_pkg::CH_SLASH, 1'b0);
          send_byte(pick_char(), $urandom_range(0, 7) == 0);
        end
        TOK_NEWLINE: send_byte(cs_pkg::CH_NL, 1'b0);
        TOK_END: send_byte(pick_char(), 1'b1);
        default: send_byte(pick_char(), 1'b0);
      endcase
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_comments();
    test_strings();
    test_text_end();
    wait_drain();
    test_output_hold();
    test_random_text();
    wait_drain();
    repeat (10) @(posedge clk);
    if (stripped_q.size() != 0) begin
      $error("%0d expected results never arrived", stripped_q.size());
      errors++;
    end
    $display("sent %0d bytes over %0d text ends, checked %0d output transfers",
             bytes_sent, texts_ended, outs_seen);
    $display("strings, escapes, both comment styles, a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
